### design/cell_text_type_classifier_core_macros.svh
// assertion macros for the cell text type classifier
`ifndef CELL_TEXT_TYPE_CLASSIFIER_CORE_MACROS_SVH
`define CELL_TEXT_TYPE_CLASSIFIER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define CTT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CTT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CTT_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CTT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### design/ctt_pkg.sv
// constants shared by the cell text type classifier
`timescale 1ns / 1ps
`default_nettype none
package ctt_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SCALE_W = 6;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned DATE_W  = 27;

  localparam logic [KIND_W-1:0] KIND_INT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DECIMAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATE    = 2'd2;

  localparam logic [CH_W-1:0] CH_DASH  = 8'h2d;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  localparam logic [POS_W-1:0] POS_DASH_A = 4'd4;
  localparam logic [POS_W-1:0] POS_DASH_B = 4'd7;
  localparam logic [POS_W-1:0] POS_DATE   = 4'd10;
  localparam logic [POS_W-1:0] POS_LIMIT  = 4'd11;

  localparam logic [SCALE_W-1:0] SCALE_LIMIT = 6'd63;

endpackage
`default_nettype wire

### design/cell_text_type_classifier_core.sv
// cell text type classifier: integer, decimal and date recognition per character
//
//  channel | direction | payload                       | handshake
//  --------+-----------+-------------------------------+------------------------
//  in      | into      | ch, last_char, empty_cell     | in_valid / in_stall
//  out     | out of    | valid_res, kind, scale, value | out_valid / out_stall
//
// one character a cycle, but for stalls at a cell end; a request sits in the input
// register, then updates the cell state, or ends the cell and loads the result register
// rst clears both stage valids and the cell state
// a full result register held by out_stall stops only requests that end a cell
// in_stall is high only while the input register holds a request that cannot move
`timescale 1ns / 1ps
`default_nettype none
`include "cell_text_type_classifier_core_macros.svh"
module cell_text_type_classifier_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  ch,
  input  wire logic        last_char,
  input  wire logic        empty_cell,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             valid_res,
  output logic [1:0]       kind,
  output logic [5:0]       scale,
  output logic signed [63:0] value
);
  import ctt_pkg::*;

  // input register
  logic              q_valid;
  logic [CH_W-1:0]   q_ch;
  logic              q_last;
  logic              q_empty;

  // cell state
  logic [POS_W-1:0]   char_position, char_position_next;
  logic               negative_sign, negative_sign_next;
  logic               dot_seen, dot_seen_next;
  logic               digit_seen, digit_seen_next;
  logic               number_broken, number_broken_next;
  logic [VALUE_W-1:0] mantissa, mantissa_next;
  logic [SCALE_W-1:0] fraction_digits, fraction_digits_next;
  logic               date_shape_ok, date_shape_ok_next;
  logic               date_digits_ok, date_digits_ok_next;
  logic [DATE_W-1:0]  date_accumulator, date_accumulator_next;

  logic               is_digit;
  logic [3:0]         digit;
  logic               q_ends;
  logic               proc_go;

  logic               res_valid;
  logic [KIND_W-1:0]  res_kind;
  logic [SCALE_W-1:0] res_scale;
  logic [VALUE_W-1:0] res_value;

  assign q_ends   = q_last | q_empty;
  assign proc_go  = q_valid & (~q_ends | ~out_valid | ~out_stall);
  assign in_stall = q_valid & ~proc_go;

  assign is_digit = q_ch inside {[CH_ZERO:CH_NINE]};
  assign digit    = is_digit ? 4'(q_ch - CH_ZERO) : 4'd0;

  always_comb begin
    char_position_next    = char_position;
    negative_sign_next    = negative_sign;
    dot_seen_next         = dot_seen;
    digit_seen_next       = digit_seen;
    number_broken_next    = number_broken;
    mantissa_next         = mantissa;
    fraction_digits_next  = fraction_digits;
    date_shape_ok_next    = date_shape_ok;
    date_digits_ok_next   = date_digits_ok;
    date_accumulator_next = date_accumulator;

    // date path
    if (char_position == POS_DASH_A || char_position == POS_DASH_B) begin
      if (q_ch != CH_DASH) begin
        date_shape_ok_next = 1'b0;
      end
    end else if (char_position < POS_DATE) begin
      if (is_digit) begin
        date_accumulator_next = (date_accumulator << 3) + (date_accumulator << 1)
                                + DATE_W'(digit);
      end else begin
        date_digits_ok_next = 1'b0;
      end
    end

    // number path
    if (char_position == '0 && q_ch == CH_DASH) begin
      negative_sign_next = 1'b1;
    end else if (char_position == '0 && q_ch == CH_PLUS) begin
      negative_sign_next = negative_sign;
    end else if (q_ch == CH_DOT) begin
      if (dot_seen) begin
        number_broken_next = 1'b1;
      end
      dot_seen_next = 1'b1;
    end else if (is_digit) begin
      mantissa_next = (mantissa << 3) + (mantissa << 1) + VALUE_W'(digit);
      if (dot_seen && fraction_digits < SCALE_LIMIT) begin
        fraction_digits_next = fraction_digits + 1'b1;
      end
      digit_seen_next = 1'b1;
    end else begin
      number_broken_next = 1'b1;
    end

    if (char_position < POS_LIMIT) begin
      char_position_next = char_position + 1'b1;
    end

    // result of a finished cell
    res_valid = 1'b0;
    res_kind  = KIND_INT;
    res_scale = '0;
    res_value = '0;
    if (!q_empty) begin
      if (char_position_next == POS_DATE && date_shape_ok_next) begin
        if (date_digits_ok_next) begin
          res_valid = 1'b1;
          res_kind  = KIND_DATE;
          res_value = VALUE_W'(date_accumulator_next);
        end
      end else if (digit_seen_next && !number_broken_next) begin
        res_valid = 1'b1;
        res_kind  = dot_seen_next ? KIND_DECIMAL : KIND_INT;
        res_scale = fraction_digits_next;
        res_value = negative_sign_next ? (VALUE_W'(0) - mantissa_next) : mantissa_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid          <= 1'b0;
      out_valid        <= 1'b0;
      char_position    <= '0;
      negative_sign    <= 1'b0;
      dot_seen         <= 1'b0;
      digit_seen       <= 1'b0;
      number_broken    <= 1'b0;
      mantissa         <= '0;
      fraction_digits  <= '0;
      date_shape_ok    <= 1'b1;
      date_digits_ok   <= 1'b1;
      date_accumulator <= '0;
    end else begin
      if (!in_stall) begin
        q_valid <= in_valid;
      end

      if (proc_go && q_ends) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (proc_go) begin
        if (q_ends) begin
          char_position    <= '0;
          negative_sign    <= 1'b0;
          dot_seen         <= 1'b0;
          digit_seen       <= 1'b0;
          number_broken    <= 1'b0;
          mantissa         <= '0;
          fraction_digits  <= '0;
          date_shape_ok    <= 1'b1;
          date_digits_ok   <= 1'b1;
          date_accumulator <= '0;
        end else begin
          char_position    <= char_position_next;
          negative_sign    <= negative_sign_next;
          dot_seen         <= dot_seen_next;
          digit_seen       <= digit_seen_next;
          number_broken    <= number_broken_next;
          mantissa         <= mantissa_next;
          fraction_digits  <= fraction_digits_next;
          date_shape_ok    <= date_shape_ok_next;
          date_digits_ok   <= date_digits_ok_next;
          date_accumulator <= date_accumulator_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_ch    <= ch;
      q_last  <= last_char;
      q_empty <= empty_cell;
    end
    if (proc_go && q_ends) begin
      valid_res <= res_valid;
      kind      <= res_kind;
      scale     <= res_scale;
      value     <= res_value;
    end
  end

  `CTT_ASSERT_SAME(a_invalid_zero, clk, rst, out_valid && !valid_res, kind == KIND_INT && scale == '0 && value == '0)
  `CTT_ASSERT_SAME(a_date_no_scale, clk, rst, out_valid && kind == KIND_DATE, scale == '0 && valid_res)
  `CTT_ASSERT_NEXT(a_cell_cleared, clk, rst, proc_go && q_ends, char_position == '0 && mantissa == '0 && date_shape_ok && out_valid)
  `CTT_ASSERT_SAME(a_stall_only_end, clk, rst, in_stall, q_valid && q_ends && out_valid && out_stall)

endmodule
`default_nettype wire

### verif/cell_verdict_checker.sv
// checker for the cell text type classifier: watches both channels, predicts cell results
`timescale 1ns / 1ps
module cell_verdict_checker
  import ctt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CH_W-1:0]    ch,
  input  logic               last_char,
  input  logic               empty_cell,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               valid_res,
  input  logic [KIND_W-1:0]  kind,
  input  logic [SCALE_W-1:0] scale,
  input  logic [VALUE_W-1:0] value,
  output int unsigned        mismatches,
  output int unsigned        outstanding
);

  typedef struct packed {
    logic               valid_res;
    logic [KIND_W-1:0]  kind;
    logic [SCALE_W-1:0] scale;
    logic [VALUE_W-1:0] value;
  } cell_verdict_t;

  cell_verdict_t      verdicts_q[$];

  logic [POS_W-1:0]   char_count;
  logic               minus_sign;
  logic               has_dot;
  logic               has_digit;
  logic               broken;
  logic [VALUE_W-1:0] mantissa_acc;
  logic [SCALE_W-1:0] frac_count;
  logic               date_shape;
  logic               date_digits;
  logic [DATE_W-1:0]  date_acc;

  task automatic clear_cell_state();
    begin
      char_count   = '0;
      minus_sign   = 1'b0;
      has_dot      = 1'b0;
      has_digit    = 1'b0;
      broken       = 1'b0;
      mantissa_acc = '0;
      frac_count   = '0;
      date_shape   = 1'b1;
      date_digits  = 1'b1;
      date_acc     = '0;
    end
  endtask

  task automatic absorb_char(input logic [CH_W-1:0] c);
    logic       is_digit;
    logic [3:0] digit;
    begin
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      digit    = is_digit ? 4'(c - CH_ZERO) : 4'd0;

      // date shape: dashes at fixed places, digits elsewhere within ten
      if (char_count == POS_DASH_A || char_count == POS_DASH_B) begin
        if (c != CH_DASH) date_shape = 1'b0;
      end else if (char_count < POS_DATE) begin
        if (is_digit) date_acc = date_acc * 27'd10 + 27'(digit);
        else date_digits = 1'b0;
      end

      // number: sign only as the first character
      if (char_count == '0 && (c == CH_DASH || c == CH_PLUS)) begin
        minus_sign = (c == CH_DASH);
      end else if (c == CH_DOT) begin
        if (has_dot) broken = 1'b1;
        has_dot = 1'b1;
      end else if (is_digit) begin
        mantissa_acc = mantissa_acc * 64'd10 + 64'(digit);
        if (has_dot && frac_count < SCALE_LIMIT) frac_count = frac_count + 1'b1;
        has_digit = 1'b1;
      end else begin
        broken = 1'b1;
      end

      if (char_count < POS_LIMIT) char_count = char_count + 1'b1;
    end
  endtask

  task automatic close_cell(input logic was_empty);
    cell_verdict_t v;
    begin
      v = '0;
      v.kind = KIND_INT;
      if (!was_empty) begin
        if (char_count == POS_DATE && date_shape) begin
          if (date_digits) begin
            v.valid_res = 1'b1;
            v.kind      = KIND_DATE;
            v.value     = VALUE_W'(date_acc);
          end
        end else if (has_digit && !broken) begin
          v.valid_res = 1'b1;
          v.kind      = has_dot ? KIND_DECIMAL : KIND_INT;
          v.scale     = frac_count;
          v.value     = minus_sign ? 64'd0 - mantissa_acc : mantissa_acc;
        end
      end
      verdicts_q = {verdicts_q, v};
      clear_cell_state();
    end
  endtask

  task automatic report_mismatch(input string what, input cell_verdict_t seen,
                                 input cell_verdict_t want);
    begin
      mismatches++;
      $display("[%0t] %s: got %0b/%0d/%0d/%0d, expected %0b/%0d/%0d/%0d (valid/kind/scale/value)",
               $time, what, seen.valid_res, seen.kind, seen.scale, $signed(seen.value),
               want.valid_res, want.kind, want.scale, $signed(want.value));
    end
  endtask

  always @(posedge clk) begin : watch
    cell_verdict_t seen;
    cell_verdict_t want;
    if (rst) begin
      verdicts_q.delete();
      clear_cell_state();
    end else begin
      if (out_valid && !out_stall) begin
        seen.valid_res = valid_res;
        seen.kind      = kind;
        seen.scale     = scale;
        seen.value     = value;
        if (verdicts_q.size() == 0) begin
          report_mismatch("result with no cell pending", seen, '0);
        end else begin
          want = verdicts_q.pop_front();
          if (seen.valid_res !== want.valid_res || seen.kind !== want.kind ||
              seen.scale !== want.scale || seen.value !== want.value) begin
            report_mismatch("cell result mismatch", seen, want);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (!empty_cell) absorb_char(ch);
        if (empty_cell || last_char) close_cell(empty_cell);
      end
    end
    outstanding = verdicts_q.size();
  end

endmodule

### verif/tb_cell_text_type_classifier_core.sv
// testbench top for the cell text type classifier: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_cell_text_type_classifier_core;
  import ctt_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned LONG_HOLD   = 80;

  typedef enum int {PH_RECV_IDLE, PH_SEND_IDLE, PH_FULL_RATE} load_phase_e;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [CH_W-1:0]     ch;
  logic                last_char;
  logic                empty_cell;
  logic                out_valid;
  logic                out_stall;
  logic                valid_res;
  logic [KIND_W-1:0]   kind;
  logic [SCALE_W-1:0]  scale;
  logic signed [63:0]  value;

  int unsigned         mismatches;
  int unsigned         outstanding;
  load_phase_e         phase = PH_RECV_IDLE;
  int unsigned         send_gap_pct = 21;
  int unsigned         recv_gap_pct = 53;
  int unsigned         requests_sent = 0;
  int unsigned         cells_sent = 0;
  int unsigned         quiet_cycles = 0;
  logic [CH_W-1:0]     cell_text[$];

  cell_text_type_classifier_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .last_char  (last_char),
    .empty_cell (empty_cell),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .valid_res  (valid_res),
    .kind       (kind),
    .scale      (scale),
    .value      (value)
  );

  cell_verdict_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .ch          (ch),
    .last_char   (last_char),
    .empty_cell  (empty_cell),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .valid_res   (valid_res),
    .kind        (kind),
    .scale       (scale),
    .value       (value),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles, giving up", $time, QUIET_LIMIT);
      $display("** cell_text_type_classifier_core: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, one long hold at the start of the full rate phase
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && phase == PH_FULL_RATE) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_gap_pct);
      end
    end
  end

  task automatic push_request(input logic [CH_W-1:0] c, input logic l, input logic e);
    begin
      @(negedge clk);
      while ($urandom_range(99) < send_gap_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid   <= 1'b1;
      ch         <= c;
      last_char  <= l;
      empty_cell <= e;
      do @(posedge clk); while (in_stall);
      requests_sent++;
    end
  endtask

  function automatic logic [CH_W-1:0] pick_char();
    int unsigned sel;
    begin
      sel = $urandom_range(25);
      if (sel < 10) return CH_ZERO + CH_W'(sel);
      if (sel == 10) return CH_DOT;
      if (sel == 11) return CH_PLUS;
      if (sel == 12) return CH_DASH;
      return CH_W'($urandom_range(255));
    end
  endfunction

  task automatic append_char(input logic [CH_W-1:0] c);
    begin
      cell_text = {cell_text, c};
    end
  endtask

  task automatic push_digits(input int unsigned n);
    begin
      repeat (n) append_char(CH_ZERO + CH_W'($urandom_range(9)));
    end
  endtask

  task automatic stream_cell();
    begin
      foreach (cell_text[i]) push_request(cell_text[i], i == cell_text.size() - 1, 1'b0);
    end
  endtask

  task automatic send_text(input string s);
    begin
      cell_text.delete();
      for (int i = 0; i < s.len(); i++) append_char(s[i]);
      stream_cell();
      cells_sent++;
    end
  endtask

  task automatic build_date();
    int unsigned twist;
    begin
      cell_text.delete();
      push_digits(4);
      append_char(CH_DASH);
      push_digits(2);
      append_char(CH_DASH);
      push_digits(2);
      twist = $urandom_range(7);
      if (twist == 0) cell_text[$urandom_range(9)] = pick_char();
      else if (twist == 1) append_char(pick_char());
      else if (twist == 2) void'(cell_text.pop_back());
    end
  endtask

  task automatic build_number(input bit spoil);
    int unsigned sign_sel;
    int unsigned spoil_sel;
    logic [CH_W-1:0] spoiler;
    begin
      cell_text.delete();
      sign_sel = $urandom_range(3);
      if (sign_sel == 2) append_char(CH_PLUS);
      else if (sign_sel == 3) append_char(CH_DASH);
      push_digits($urandom_range(8));
      if ($urandom_range(1)) begin
        append_char(CH_DOT);
        push_digits($urandom_range(6));
      end
      if (spoil) begin
        spoil_sel = $urandom_range(3);
        if (spoil_sel == 0) spoiler = CH_DOT;
        else if (spoil_sel == 1) spoiler = CH_PLUS;
        else if (spoil_sel == 2) spoiler = CH_DASH;
        else spoiler = CH_W'($urandom_range(255));
        cell_text.insert($urandom_range(cell_text.size()), spoiler);
      end
      if (cell_text.size() == 0) append_char(pick_char());
    end
  endtask

  // long digit runs: mantissa wraparound or scale saturation
  task automatic build_long();
    begin
      cell_text.delete();
      if ($urandom_range(1)) begin
        if ($urandom_range(1)) append_char(CH_DASH);
        push_digits($urandom_range(19, 26));
      end else begin
        push_digits($urandom_range(3));
        append_char(CH_DOT);
        push_digits($urandom_range(62, 70));
      end
    end
  endtask

  task automatic build_noise();
    begin
      cell_text.delete();
      repeat ($urandom_range(1, 12)) append_char(pick_char());
    end
  endtask

  task automatic random_cell();
    int unsigned pick;
    begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_request(CH_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end else if (pick < 13) begin
        // partial cell dropped by an empty marker
        repeat ($urandom_range(1, 6)) push_request(pick_char(), 1'b0, 1'b0);
        push_request(CH_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end else begin
        if (pick < 16) build_long();
        else if (pick < 40) build_date();
        else if (pick < 75) build_number(1'b0);
        else if (pick < 88) build_number(1'b1);
        else build_noise();
        stream_cell();
      end
      cells_sent++;
    end
  endtask

  initial begin : stimulus
    int unsigned waited;
    rst        = 1'b1;
    in_valid   = 1'b0;
    ch         = '0;
    last_char  = 1'b0;
    empty_cell = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    push_request(8'hff, 1'b1, 1'b1);
    cells_sent++;
    send_text("1999-06-30");
    send_text("-7");
    send_text("+.5");
    send_text(".");
    send_text("5-");
    send_text("1..");
    cell_text = '{8'h00, 8'hff};
    stream_cell();
    cells_sent++;

    while (requests_sent < 580) random_cell();
    phase        = PH_SEND_IDLE;
    send_gap_pct = 53;
    recv_gap_pct = 21;
    while (requests_sent < 1160) random_cell();
    phase        = PH_FULL_RATE;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    while (requests_sent < 1750) random_cell();

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (outstanding != 0) $display("%0d cell results never arrived", outstanding);
    $display("run covered %0d requests in %0d cells: dates, integers, decimals, signs,",
             requests_sent, cells_sent);
    $display("stray bytes, empty and dropped cells, wraparound, scale saturation, long hold");
    if (mismatches == 0 && outstanding == 0) begin
      $display("** cell_text_type_classifier_core: PASSED **");
    end else begin
      $display("** cell_text_type_classifier_core: FAILED **");
    end
    $finish;
  end

endmodule

### cell_text_type_classifier_core.f
+incdir+design
design/ctt_pkg.sv
design/cell_text_type_classifier_core.sv
verif/cell_verdict_checker.sv
verif/tb_cell_text_type_classifier_core.sv
